[design/assert_macros.svh]
// assertion macros for the rtl files (included by u8u16_emit)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

[design/u8u16_pkg.sv]
// shared types, constants and helper functions of the utf-8 to utf-16 decoder
`default_nettype none

package u8u16_pkg;

    localparam int unsigned MAX_UNITS_DEF = 65536;

    localparam int BYTE_W     = 8;
    localparam int UNIT_W     = 16;
    localparam int TOTAL_W    = 17;
    localparam int STATUS_W   = 2;
    localparam int ACC_W      = 32;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - UNIT_W - TOTAL_W;

    localparam logic [ACC_W-1:0]  CP_LIMIT     = 32'h0011_0000;
    localparam logic [ACC_W-1:0]  BMP_MAX      = 32'h0000_FFFF;
    localparam logic [UNIT_W-1:0] SURR_HI_OFS  = 16'hD7C0;
    localparam logic [UNIT_W-1:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h3F;
    localparam logic [1:0]        CONT_TAG     = 2'b10;

    typedef enum logic [STATUS_W-1:0] {
        ST_UNIT = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    // results caused by one byte
    typedef struct packed {
        logic [UNIT_W-1:0]  unit0;
        logic [UNIT_W-1:0]  unit1;
        logic [1:0]         n_units;
        logic               closing;
        status_t            close_status;
        logic [TOTAL_W-1:0] total;
    } bundle_t;

    // largest value the next shorter form can carry
    function automatic logic [ACC_W-1:0] overlong_bound(input logic [2:0] cls);
        logic [ACC_W-1:0] bound;
        case (cls)
            3'd0:    bound = 32'h0000_007F;
            3'd1:    bound = 32'h0000_07FF;
            3'd2:    bound = 32'h0000_FFFF;
            3'd3:    bound = 32'h001F_FFFF;
            3'd4:    bound = 32'h03FF_FFFF;
            3'd5:    bound = 32'h7FFF_FFFF;
            default: bound = 32'hFFFF_FFFF;
        endcase
        return bound;
    endfunction

    // count of leading one bits of a byte
    function automatic logic [3:0] lead_ones(input logic [BYTE_W-1:0] b);
        logic [3:0] cnt;
        logic       run;
        cnt = 4'd0;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (run && b[i])
            begin
                cnt = cnt + 4'd1;
            end
            else
            begin
                run = 1'b0;
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

[design/u8u16_decode.sv]
// sequence state and per-byte decode of utf-8 into utf-16 units
`default_nettype none

module u8u16_decode #(
    parameter int unsigned MAX_UNITS = u8u16_pkg::MAX_UNITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [u8u16_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic                           eos,
    output u8u16_pkg::bundle_t                  bundle
);

    localparam int CNT_W = $clog2(MAX_UNITS + 1);

    logic [2:0]                      pend_reg, pend_next;
    logic [u8u16_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [2:0]                      cls_reg, cls_next;
    logic                            fail_reg, fail_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;

    logic [3:0]                      lead;
    logic [u8u16_pkg::ACC_W-1:0]     cp;
    logic [CNT_W:0]                  cnt_sum;
    logic [u8u16_pkg::UNIT_W-1:0]    u0, u1;
    logic [1:0]                      nu;

    always_comb
    begin
        pend_next = pend_reg;
        acc_next  = acc_reg;
        cls_next  = cls_reg;
        fail_next = fail_reg;
        cnt_next  = cnt_reg;
        u0        = '0;
        u1        = '0;
        nu        = 2'd0;
        lead      = u8u16_pkg::lead_ones(byte_in);
        cp        = {acc_reg[u8u16_pkg::ACC_W-7:0], byte_in[5:0]};
        cnt_sum   = '0;

        if (!fail_reg)
        begin
            if (pend_reg != 3'd0)
            begin
                if (byte_in[7:6] != u8u16_pkg::CONT_TAG)
                begin
                    fail_next = 1'b1;
                end
                else
                begin
                    acc_next  = cp;
                    pend_next = pend_reg - 3'd1;
                    if (pend_reg == 3'd1)
                    begin
                        if (cp <= u8u16_pkg::overlong_bound(cls_reg))
                        begin
                            fail_next = 1'b1;
                        end
                        else if (cp >= u8u16_pkg::CP_LIMIT)
                        begin
                            fail_next = 1'b1;
                        end
                        else if (cp <= u8u16_pkg::BMP_MAX)
                        begin
                            u0 = cp[15:0];
                            nu = 2'd1;
                        end
                        else
                        begin
                            // surrogate pair
                            u0 = cp[25:10] + u8u16_pkg::SURR_HI_OFS;
                            u1 = {6'd0, cp[9:0]} + u8u16_pkg::SURR_LO_BASE;
                            nu = 2'd2;
                        end
                    end
                end
            end
            else
            begin
                if (lead == 4'd0)
                begin
                    u0 = {8'd0, byte_in};
                    nu = 2'd1;
                end
                else if (lead == 4'd1 || lead >= 4'd7)
                begin
                    fail_next = 1'b1;
                end
                else
                begin
                    pend_next = lead[2:0] - 3'd1;
                    cls_next  = lead[2:0] - 3'd2;
                    acc_next  = {24'd0, byte_in & (u8u16_pkg::CONT_MASK >> (lead - 4'd1))};
                end
            end

            // capacity check drops every unit of the code point
            if (!fail_next && nu != 2'd0)
            begin
                cnt_sum = {1'b0, cnt_reg} + (CNT_W + 1)'(nu);
                if (cnt_sum > (CNT_W + 1)'(MAX_UNITS))
                begin
                    fail_next = 1'b1;
                    nu        = 2'd0;
                end
                else
                begin
                    cnt_next = cnt_sum[CNT_W-1:0];
                end
            end
        end

        // cut-off sequence at end of string
        if (eos && !fail_next && pend_next != 3'd0)
        begin
            fail_next = 1'b1;
        end

        bundle.unit0        = u0;
        bundle.unit1        = u1;
        bundle.n_units      = nu;
        bundle.closing      = eos;
        bundle.close_status = fail_next ? u8u16_pkg::ST_FAIL : u8u16_pkg::ST_DONE;
        bundle.total        = fail_next ? '0 : u8u16_pkg::TOTAL_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            acc_reg  <= '0;
            cls_reg  <= '0;
            fail_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (step)
        begin
            if (eos)
            begin
                pend_reg <= '0;
                acc_reg  <= '0;
                cls_reg  <= '0;
                fail_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else
            begin
                pend_reg <= pend_next;
                acc_reg  <= acc_next;
                cls_reg  <= cls_next;
                fail_reg <= fail_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

[design/u8u16_emit.sv]
// result register that hands out the results of one byte, one item per cycle while m_tready is high
`default_nettype none
`include "assert_macros.svh"

module u8u16_emit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire u8u16_pkg::bundle_t                  bundle,
    output logic                                     can_load,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [u8u16_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic [u8u16_pkg::STATUS_W-1:0]           m_tuser,
    output logic                                     m_tlast
);

    u8u16_pkg::bundle_t               bun_reg;
    logic [1:0]                       left_reg;
    logic [1:0]                       pos_reg;

    logic                             is_unit;
    logic [u8u16_pkg::UNIT_W-1:0]     code;
    logic [u8u16_pkg::TOTAL_W-1:0]    total;
    u8u16_pkg::status_t               status;

    assign m_tvalid = (left_reg != 2'd0);
    assign can_load = (left_reg == 2'd0) || (left_reg == 2'd1 && m_tready);

    always_comb
    begin
        is_unit = (pos_reg < bun_reg.n_units);
        if (is_unit)
        begin
            code   = (pos_reg == 2'd0) ? bun_reg.unit0 : bun_reg.unit1;
            status = u8u16_pkg::ST_UNIT;
            total  = '0;
        end
        else
        begin
            code   = '0;
            status = bun_reg.close_status;
            total  = bun_reg.total;
        end
    end

    assign m_tdata = {{u8u16_pkg::OUT_PAD_W{1'b0}}, total, code};
    assign m_tuser = status;
    assign m_tlast = (left_reg == 2'd1);

    // payload only changes on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bun_reg <= bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
            pos_reg  <= 2'd0;
        end
        else if (load)
        begin
            left_reg <= bundle.n_units + {1'b0, bundle.closing};
            pos_reg  <= 2'd0;
        end
        else if (m_tvalid && m_tready)
        begin
            left_reg <= left_reg - 2'd1;
            pos_reg  <= pos_reg + 2'd1;
        end
    end

    `ASSERT_PROP(a_close_is_last, clk, rst_n,
        (m_tvalid && m_tuser != u8u16_pkg::ST_UNIT) |-> m_tlast,
        "closing item not marked last")
    `ASSERT_PROP(a_fail_no_payload, clk, rst_n,
        (m_tvalid && m_tuser == u8u16_pkg::ST_FAIL) |-> (m_tdata == '0),
        "failed closing item carries data")
    `ASSERT_PROP(a_drained_idle, clk, rst_n,
        (m_tvalid && m_tready && m_tlast && !load) |=> !m_tvalid,
        "output still valid after last item taken")

endmodule

`default_nettype wire

[design/utf8_to_utf16_decoder.sv]
// top level of the utf-8 to utf-16 string decoder
`default_nettype none

// utf-8 to utf-16 decoder: takes one utf-8 byte per item on the s_ side, with
// s_tlast marking the final byte of a string, and gives utf-16 code units on
// the m_ side (a surrogate pair above 0xffff). on the final byte a closing item
// follows with status done and the unit count, or status failed when anything
// in the string was malformed (lone or missing continuation, cut-off sequence,
// overlong form, value of 0x110000 or more, lead byte 0xfe/0xff, or more than
// MAX_UNITS units). after a failure the rest of the string gives no units.
// timing: an accepted byte waits in the input register until the result
// register can take its results, is decoded in one pass against the sequence
// state and is loaded into the result register, which hands out its results.
// a byte that gives at most one result is taken every cycle while m_tready is
// high; a byte giving n results (up to three: a surrogate pair plus the
// closing item) holds the result register until all are taken, since the
// output hands out one item per cycle while m_tready is high. one further byte
// can be taken into the input register while a result waits on m_tready.
module utf8_to_utf16_decoder #(
    parameter int unsigned MAX_UNITS = u8u16_pkg::MAX_UNITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] byte_in
    input  wire logic                                s_tlast,   // end_of_string
    // result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [u8u16_pkg::OUT_DATA_W-1:0]         m_tdata,   // [15:0] code_unit, [32:16] unit_total, rest zero
    output logic [u8u16_pkg::STATUS_W-1:0]           m_tuser,   // [1:0] status
    output logic                                     m_tlast    // last_of_run
);

    // input register
    logic                              in_valid_reg;
    logic [u8u16_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                              in_eos_reg;

    logic                              can_load;
    logic                              advance;
    u8u16_pkg::bundle_t                bundle;

    // byte moves into decode when the result register can take its results
    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    // sequence state and single-pass decode
    u8u16_decode #(
        .MAX_UNITS (MAX_UNITS)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte_reg),
        .eos     (in_eos_reg),
        .bundle  (bundle)
    );

    // result register and output sequencing
    u8u16_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .bundle   (bundle),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[verif/utf8_to_utf16_decoder_test.sv]
// self-checking testbench of the utf-8 to utf-16 string decoder
module utf8_to_utf16_decoder_test;

    // a small unit cap keeps the capacity failure within reach of short strings
    localparam int unsigned UNIT_CAP = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_BYTES = 96;
    localparam int DRAIN_CYCLES = 20;

    // one result item as the block gives it
    typedef struct packed {
        logic [15:0]          code_unit;
        u8u16_pkg::status_t   status;
        logic [16:0]          total;
        logic                 last;
    } utf16_item_t;

    // one row of the directed table: a byte, its end flag, and either a
    // typed-in result (exactly one item) or nothing, in which case the
    // decoder model below supplies the expectation
    typedef struct packed {
        logic [7:0]  byte_val;
        logic        eos;
        logic        typed;
        utf16_item_t res;
    } stim_row_t;

    localparam utf16_item_t NO_ITEM   = '0;
    localparam utf16_item_t FAIL_ITEM = '{16'h0000, u8u16_pkg::ST_FAIL, 17'd0, 1'b1};

    localparam stim_row_t DIRECTED [24] = '{
        // zero byte as a one-byte code point, then the largest ascii value
        '{8'h00, 1'b0, 1'b1, '{16'h0000, u8u16_pkg::ST_UNIT, 17'd0, 1'b1}},
        '{8'h7F, 1'b0, 1'b1, '{16'h007F, u8u16_pkg::ST_UNIT, 17'd0, 1'b1}},
        // lone continuation where a lead byte is due
        '{8'h80, 1'b1, 1'b1, FAIL_ITEM},
        // lead bytes that always fail
        '{8'hFE, 1'b1, 1'b1, FAIL_ITEM},
        '{8'hFF, 1'b1, 1'b1, FAIL_ITEM},
        // smallest two-byte form
        '{8'hC2, 1'b0, 1'b0, NO_ITEM},
        '{8'h80, 1'b1, 1'b0, NO_ITEM},
        // overlong two-byte form
        '{8'hC1, 1'b0, 1'b0, NO_ITEM},
        '{8'hBF, 1'b1, 1'b1, FAIL_ITEM},
        // surrogate code point passes unchecked
        '{8'hED, 1'b0, 1'b0, NO_ITEM},
        '{8'hA0, 1'b0, 1'b0, NO_ITEM},
        '{8'h80, 1'b0, 1'b0, NO_ITEM},
        // largest code point: surrogate pair plus the closing item on one byte
        '{8'hF4, 1'b0, 1'b0, NO_ITEM},
        '{8'h8F, 1'b0, 1'b0, NO_ITEM},
        '{8'hBF, 1'b0, 1'b0, NO_ITEM},
        '{8'hBF, 1'b1, 1'b0, NO_ITEM},
        // just out of range
        '{8'hF4, 1'b0, 1'b0, NO_ITEM},
        '{8'h90, 1'b0, 1'b0, NO_ITEM},
        '{8'h80, 1'b0, 1'b0, NO_ITEM},
        '{8'h80, 1'b1, 1'b1, FAIL_ITEM},
        // missing continuation, then a byte ignored after the failure
        '{8'hE2, 1'b0, 1'b0, NO_ITEM},
        '{8'h41, 1'b0, 1'b0, NO_ITEM},
        '{8'h42, 1'b1, 1'b1, FAIL_ITEM},
        // sequence cut off by the end of the string
        '{8'hC3, 1'b1, 1'b1, FAIL_ITEM}
    };

    logic                                 clk;
    logic                                 rst_n    = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [7:0]                           s_tdata  = 8'h00;
    logic                                 s_tlast  = 1'b0;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [u8u16_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic [u8u16_pkg::STATUS_W-1:0]       m_tuser;
    logic                                 m_tlast;

    // decoder model state, cleared after every end byte
    logic [2:0]  cont_left;
    logic [31:0] cp_acc;
    logic [2:0]  form_class;
    bit          str_failed;
    int unsigned str_units;

    utf16_item_t awaited_units[$];
    logic [7:0]  utf8_seq[$];
    int          mismatches  = 0;
    int          random_bytes = 0;
    bit          calm = 1'b0;

    utf8_to_utf16_decoder #(
        .MAX_UNITS (UNIT_CAP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // largest value that a form of len bytes can carry
    function automatic logic [31:0] form_max(input int len);
        case (len)
            1:       return 32'h0000_007F;
            2:       return 32'h0000_07FF;
            3:       return 32'h0000_FFFF;
            4:       return 32'h001F_FFFF;
            5:       return 32'h03FF_FFFF;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic void clear_decoder_state();
        cont_left  = '0;
        cp_acc     = '0;
        form_class = '0;
        str_failed = 1'b0;
        str_units  = 0;
    endfunction

    // adds one item to the tail of the awaited results
    function automatic void expect_item(input utf16_item_t it);
        awaited_units.insert(awaited_units.size(), it);
    endfunction

    // adds one byte to the tail of the string being built
    function automatic void append_byte(input logic [7:0] b);
        utf8_seq.insert(utf8_seq.size(), b);
    endfunction

    // advances the decoder model by one byte; with record set, the items the
    // byte causes are queued as expected
    function automatic void decode_byte(input logic [7:0] b, input logic eos, input bit record);
        logic [15:0] produced [2];
        logic [31:0] hi;
        int          n_prod;
        int          n_out;
        int          lead;
        utf16_item_t item;
        n_prod = 0;
        if (!str_failed)
        begin
            if (cont_left != 0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    str_failed = 1'b1;
                end
                else
                begin
                    cp_acc    = {cp_acc[25:0], b[5:0]};
                    cont_left = cont_left - 3'd1;
                    if (cont_left == 0)
                    begin
                        // overlong: fits the next shorter form
                        if (cp_acc <= form_max(form_class + 1))
                        begin
                            str_failed = 1'b1;
                        end
                        else if (cp_acc >= 32'h0011_0000)
                        begin
                            str_failed = 1'b1;
                        end
                        else if (cp_acc <= 32'h0000_FFFF)
                        begin
                            produced[0] = cp_acc[15:0];
                            n_prod = 1;
                        end
                        else
                        begin
                            hi = (cp_acc >> 10) + 32'h0000_D7C0;
                            produced[0] = hi[15:0];
                            produced[1] = {6'b110111, cp_acc[9:0]};
                            n_prod = 2;
                        end
                    end
                end
            end
            else
            begin
                lead = 0;
                while (lead < 8 && b[7 - lead])
                begin
                    lead++;
                end
                if (lead == 0)
                begin
                    produced[0] = {8'h00, b};
                    n_prod = 1;
                end
                else if (lead == 1 || lead >= 7)
                begin
                    str_failed = 1'b1;
                end
                else
                begin
                    cont_left  = 3'(lead - 1);
                    form_class = 3'(lead - 2);
                    cp_acc     = {24'h0, b & (8'h3F >> (lead - 1))};
                end
            end
            // capacity: a code point that would overrun the cap gives nothing
            if (!str_failed && n_prod > 0)
            begin
                if (str_units + n_prod > UNIT_CAP)
                begin
                    str_failed = 1'b1;
                    n_prod = 0;
                end
                else
                begin
                    str_units += n_prod;
                end
            end
        end
        if (eos && !str_failed && cont_left != 0)
        begin
            str_failed = 1'b1;
        end
        n_out = n_prod + (eos ? 1 : 0);
        if (record)
        begin
            for (int k = 0; k < n_prod; k++)
            begin
                item = '{produced[k], u8u16_pkg::ST_UNIT, 17'd0, (k == n_out - 1)};
                expect_item(item);
            end
            if (eos)
            begin
                if (str_failed)
                begin
                    expect_item(FAIL_ITEM);
                end
                else
                begin
                    item = '{16'h0000, u8u16_pkg::ST_DONE, 17'(str_units), 1'b1};
                    expect_item(item);
                end
            end
        end
        if (eos)
        begin
            clear_decoder_state();
        end
    endfunction

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // appends cp as a form of len bytes, whether or not that form is legal
    function automatic void encode_form(input logic [31:0] cp, input int len);
        logic [31:0] t;
        logic [7:0]  lead_byte;
        if (len == 1)
        begin
            append_byte(cp[7:0]);
        end
        else
        begin
            t = cp >> (6 * (len - 1));
            lead_byte = (8'hFF << (8 - len)) | t[7:0];
            append_byte(lead_byte);
            for (int i = len - 2; i >= 0; i--)
            begin
                t = cp >> (6 * i);
                append_byte({2'b10, t[5:0]});
            end
        end
    endfunction

    function automatic void add_code_point(input int len);
        logic [31:0] cp;
        case (len)
            1:       cp = $urandom_range(1, 127);
            4:       cp = $urandom_range(32'h0001_0000, 32'h0010_FFFF);
            default: cp = $urandom_range(form_max(len - 1) + 1, form_max(len));
        endcase
        encode_form(cp, len);
    endfunction

    function automatic void add_malformed();
        int          len;
        int          cut;
        logic [31:0] lo;
        logic [5:0]  tail;
        case ($urandom_range(0, 5))
            0:
            begin
                // lone continuation
                tail = 6'($urandom_range(0, 63));
                append_byte({2'b10, tail});
            end
            1:
            begin
                // overlong form
                len = $urandom_range(2, 4);
                encode_form($urandom_range(0, form_max(len - 1)), len);
            end
            2:
            begin
                // out of range, five- and six-byte forms included
                len = $urandom_range(4, 6);
                lo  = (len == 4) ? 32'h0011_0000 : form_max(len - 1) + 1;
                encode_form($urandom_range(lo, form_max(len)), len);
            end
            3:
            begin
                append_byte($urandom_range(0, 1) ? 8'hFE : 8'hFF);
            end
            4:
            begin
                // sequence missing one or more continuations
                len = $urandom_range(2, 4);
                add_code_point(len);
                cut = $urandom_range(1, len - 1);
                repeat (cut) void'(utf8_seq.pop_back());
            end
            default:
            begin
                append_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        $display("mismatch at %0t: %s expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic check_result();
        utf16_item_t want;
        if (awaited_units.size() == 0)
        begin
            report_mismatch("item with none awaited", 40'h0, m_tdata);
            return;
        end
        want = awaited_units.pop_front();
        if (m_tdata[15:0] !== want.code_unit)
            report_mismatch("code_unit", want.code_unit, m_tdata[15:0]);
        if (m_tuser !== want.status)
            report_mismatch("status", want.status, m_tuser);
        if (m_tdata[32:16] !== want.total)
            report_mismatch("unit_total", want.total, m_tdata[32:16]);
        if (m_tdata[u8u16_pkg::OUT_DATA_W-1:33] !== '0)
            report_mismatch("tdata padding", 40'h0, m_tdata[u8u16_pkg::OUT_DATA_W-1:33]);
        if (m_tlast !== want.last)
            report_mismatch("last_of_run", want.last, m_tlast);
    endtask

    // offers one byte after a random gap and returns once it is taken;
    // valid stays high into the next item unless that one starts with a gap
    task automatic send_byte(input logic [7:0] b, input logic eos, input bit record);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        decode_byte(b, eos, record);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // a random string: well-formed code points, or with one malformed
    // piece at a random place when dirty is set
    task automatic send_random_string(input bit dirty);
        int n_cp;
        int bad_at;
        int n_bytes;
        utf8_seq.delete();
        n_cp   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        bad_at = dirty ? $urandom_range(0, n_cp - 1) : -1;
        for (int i = 0; i < n_cp; i++)
        begin
            if (i == bad_at)
                add_malformed();
            else
                add_code_point($urandom_range(1, 4));
        end
        n_bytes = utf8_seq.size();
        for (int i = 0; i < n_bytes; i++)
        begin
            send_byte(utf8_seq[i], (i == n_bytes - 1), 1'b1);
        end
        random_bytes += n_bytes;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (awaited_units.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // result side: checks every accepted item and stalls at random
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                check_result();
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    // watchdog: ends the run when no item moves on either side for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // stimulus: directed table, a full drain, then random strings with a
    // stretch free of idling and a second drain part way through
    initial
    begin
        int n_str;
        n_str = 0;
        clear_decoder_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].typed)
            begin
                expect_item(DIRECTED[i].res);
            end
            send_byte(DIRECTED[i].byte_val, DIRECTED[i].eos, !DIRECTED[i].typed);
        end

        // sender holds off until every awaited item is back
        wait_for_drain();

        while (random_bytes < RANDOM_BYTES)
        begin
            calm = (n_str >= 6 && n_str < 12);
            send_random_string($urandom_range(0, 3) == 0);
            n_str++;
            if (n_str == 15)
            begin
                wait_for_drain();
            end
        end
        calm = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
